// ===== hdl/sbli_pkg.sv =====
// shared constants, op codes and controller/datapath handshake structs
// for the segment versus box-table intersection block; no dependencies
`timescale 1ns / 1ps

package sbli_pkg;

  localparam int MAX_BOXES_DEF  = 64;
  localparam int COORD_BITS_DEF = 32;
  localparam int FIELD_BITS     = 32;
  localparam int MARGIN_BITS    = 31;
  localparam int OP_BITS        = 2;
  // digit width of the shared cross multiply unit
  localparam int DIGIT_BITS     = 16;

  localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_BITS-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_BITS-1:0] OP_TEST  = 2'd2;

  // which fraction compare the multiply unit runs
  localparam logic [1:0] SEL_ENTRY = 2'd0;
  localparam logic [1:0] SEL_EXIT  = 2'd1;
  localparam logic [1:0] SEL_SPAN  = 2'd2;

  typedef struct packed {
    logic       latch_in;
    logic       clr_count;
    logic       add_box;
    logic       k_first;
    logic       k_next;
    logic       mem_rd;
    logic       axis_first;
    logic       axis_next;
    logic       stage_a;
    logic       stage_b;
    logic       cmp_start;
    logic [1:0] cmp_sel;
    logic       set_res;
    logic       res_hit;
    logic       res_status;
    logic       push_out;
  } cmd_t;

  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic               full;
    logic               empty;
    logic               last_box;
    logic               last_axis;
    logic               zero_dir;
    logic               slab_fail;
    logic               cmp_done;
    logic               cmp_fail;
    logic               out_busy;
  } sts_t;

endpackage

// ===== hdl/sbli_ifs.sv =====
// handshake channel interfaces: request, result and margin write
// depends on sbli_pkg for field widths
`timescale 1ns / 1ps

interface sbli_req_if;
  logic                             valid;
  logic                             ready;
  logic [sbli_pkg::OP_BITS-1:0]     op;
  logic [sbli_pkg::FIELD_BITS-1:0]  a_x;
  logic [sbli_pkg::FIELD_BITS-1:0]  a_y;
  logic [sbli_pkg::FIELD_BITS-1:0]  a_z;
  logic [sbli_pkg::FIELD_BITS-1:0]  b_x;
  logic [sbli_pkg::FIELD_BITS-1:0]  b_y;
  logic [sbli_pkg::FIELD_BITS-1:0]  b_z;
  modport source (output valid, op, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
  modport sink   (input valid, op, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

interface sbli_rsp_if;
  logic valid;
  logic ready;
  logic hit;
  logic status;
  modport source (output valid, hit, status, input ready);
  modport sink   (input valid, hit, status, output ready);
endinterface

interface sbli_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sbli_pkg::MARGIN_BITS-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/sbli_datapath.sv =====
// datapath: box table memory, slab bound arithmetic, digit-serial cross
// multiply compare unit and result register; depends on sbli_pkg
`timescale 1ns / 1ps

module sbli_datapath #(
  parameter int MAX_BOXES  = sbli_pkg::MAX_BOXES_DEF,
  parameter int COORD_BITS = sbli_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  sbli_pkg::cmd_t                   cmd,
  output sbli_pkg::sts_t                   sts,
  input  logic [sbli_pkg::OP_BITS-1:0]     req_op,
  input  logic [sbli_pkg::FIELD_BITS-1:0]  req_a [3],
  input  logic [sbli_pkg::FIELD_BITS-1:0]  req_b [3],
  input  logic                             cfg_we,
  input  logic [sbli_pkg::MARGIN_BITS-1:0] cfg_data,
  input  logic                             out_take,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic                             out_status
);

  localparam int C   = COORD_BITS;
  localparam int CW  = $clog2(MAX_BOXES + 1);
  localparam int AW  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int MB  = sbli_pkg::MARGIN_BITS;
  localparam int WB  = ((C > MB + 1) ? C : MB + 1) + 4;
  localparam int DG  = sbli_pkg::DIGIT_BITS;
  localparam int ND  = (WB + DG - 1) / DG;
  localparam int PW  = ND * DG;
  localparam int ACW = 2 * WB;
  localparam int NW  = $clog2(ND + 1);
  localparam int RW  = 6 * C;

  logic [sbli_pkg::OP_BITS-1:0] op;
  logic [C-1:0]    sa [3];
  logic [C-1:0]    sb [3];
  logic [CW-1:0]   count;
  logic [MB-1:0]   margin;
  logic [RW-1:0]   mem [MAX_BOXES];
  logic [RW-1:0]   row;
  logic [AW-1:0]   k;
  logic [1:0]      axis;

  logic signed [WB-1:0] n1r, n2r, dr;
  logic [WB-1:0]   n1c, n2c, dd;
  logic            zero_dir, slab_fail;
  logic [WB-1:0]   tn, td, xn, xd;

  logic [WB-1:0]   ma, mc;
  logic [PW-1:0]   me, mb;
  logic [ACW-1:0]  acc1, acc2;
  logic [NW-1:0]   cnt;
  logic            busy, done;
  logic [1:0]      sel;
  logic            res_hit, res_status;

  // stage a
  logic signed [WB-1:0] c2, sz, m2, s2, e2;
  // stage b
  logic signed [WB-1:0] a1, a2, ad, lo_v, hi_v;
  logic            neg;
  // compare
  logic [WB-1:0]   op_a, op_b, op_c, op_e;
  logic            gt, lt;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      margin    <= '0;
      busy      <= 1'b0;
      done      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) margin <= cfg_data;
      if (cmd.clr_count) count <= '0;
      else if (cmd.add_box) count <= count + CW'(1);
      done <= 1'b0;
      if (cmd.cmp_start) begin
        busy <= 1'b1;
      end else if (busy && cnt == NW'(ND - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
      if (cmd.push_out) out_valid <= 1'b1;
      else if (out_take) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op <= req_op;
      for (int i = 0; i < 3; i++) begin
        sa[i] <= C'(req_a[i]);
        sb[i] <= C'(req_b[i]);
      end
    end
    if (cmd.add_box) mem[count[AW-1:0]] <= {sb[2], sb[1], sb[0], sa[2], sa[1], sa[0]};
    if (cmd.mem_rd) row <= mem[k];
  end

  always_ff @(posedge clk) begin
    if (cmd.k_first) k <= '0;
    else if (cmd.k_next) k <= k + AW'(1);
    if (cmd.axis_first) begin
      axis <= 2'd0;
      tn <= '0;
      td <= WB'(1);
      xn <= WB'(1);
      xd <= WB'(1);
    end else begin
      if (cmd.axis_next) axis <= axis + 2'd1;
      if (done && sel == sbli_pkg::SEL_ENTRY && gt) begin
        tn <= n1c;
        td <= dd;
      end
      if (done && sel == sbli_pkg::SEL_EXIT && lt) begin
        xn <= n2c;
        xd <= dd;
      end
    end
  end

  // slab bounds in doubled units, relative to the segment start
  always_comb begin
    c2 = WB'(signed'(row[32'(axis) * C +: C])) <<< 1;
    sz = WB'(signed'(row[(32'(axis) + 3) * C +: C]));
    m2 = signed'(WB'({margin, 1'b0}));
    s2 = WB'(signed'(sa[axis])) <<< 1;
    e2 = WB'(signed'(sb[axis])) <<< 1;
  end

  always_comb begin
    neg  = dr[WB-1];
    a1   = neg ? -n1r : n1r;
    a2   = neg ? -n2r : n2r;
    ad   = neg ? -dr : dr;
    lo_v = (a1 > a2) ? a2 : a1;
    hi_v = (a1 > a2) ? a1 : a2;
  end

  always_ff @(posedge clk) begin
    if (cmd.stage_a) begin
      n1r <= c2 - sz - m2 - s2;
      n2r <= c2 + sz + m2 - s2;
      dr  <= e2 - s2;
    end
    if (cmd.stage_b) begin
      zero_dir  <= (dr == '0);
      if (dr == '0) slab_fail <= (n1r > 0) || (n2r < 0);
      else slab_fail <= (lo_v > ad) || (hi_v < 0);
      dd  <= unsigned'(ad);
      n1c <= (lo_v < 0) ? '0 : unsigned'(lo_v);
      n2c <= (hi_v > ad) ? unsigned'(ad) : unsigned'(hi_v);
    end
  end

  // a/b against c/e through a*e and c*b, msb digit first
  always_comb begin
    unique case (cmd.cmp_sel)
      sbli_pkg::SEL_ENTRY: begin
        op_a = n1c; op_b = dd; op_c = tn; op_e = td;
      end
      sbli_pkg::SEL_EXIT: begin
        op_a = n2c; op_b = dd; op_c = xn; op_e = xd;
      end
      default: begin
        op_a = tn; op_b = td; op_c = xn; op_e = xd;
      end
    endcase
    gt = acc1 > acc2;
    lt = acc1 < acc2;
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp_start) begin
      sel  <= cmd.cmp_sel;
      ma   <= op_a;
      mc   <= op_c;
      me   <= PW'(op_e);
      mb   <= PW'(op_b);
      acc1 <= '0;
      acc2 <= '0;
      cnt  <= '0;
    end else if (busy) begin
      acc1 <= (acc1 << DG) + ACW'(ma * me[PW-1 -: DG]);
      acc2 <= (acc2 << DG) + ACW'(mc * mb[PW-1 -: DG]);
      me   <= me << DG;
      mb   <= mb << DG;
      cnt  <= cnt + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_hit    <= cmd.res_hit;
      res_status <= cmd.res_status;
    end
    if (cmd.push_out) begin
      out_hit    <= res_hit;
      out_status <= res_status;
    end
  end

  always_comb begin
    sts.op        = op;
    sts.full      = (count == CW'(MAX_BOXES));
    sts.empty     = (count == '0);
    sts.last_box  = (CW'(k) + CW'(1) == count);
    sts.last_axis = (axis == 2'd2);
    sts.zero_dir  = zero_dir;
    sts.slab_fail = slab_fail;
    sts.cmp_done  = done;
    sts.cmp_fail  = done && sel == sbli_pkg::SEL_SPAN && gt;
    sts.out_busy  = out_valid;
  end

endmodule

// ===== hdl/sbli_ctrl.sv =====
// controller state machine: op decode, box and axis walk, compare sequencing
// depends on sbli_pkg
`timescale 1ns / 1ps

module sbli_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_fire,
  output logic           req_ready,
  input  sbli_pkg::sts_t sts,
  output sbli_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_RD, S_SA, S_SB, S_CHK, S_W0, S_W1, S_SP, S_W2, S_FIN
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    logic box_miss, axis_pass;
    cmd        = '0;
    state_next = state;
    box_miss   = 1'b0;
    axis_pass  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          cmd.latch_in = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next  = S_FIN;
        cmd.set_res = 1'b1;
        case (sts.op)
          sbli_pkg::OP_CLEAR: cmd.clr_count = 1'b1;
          sbli_pkg::OP_ADD: begin
            if (sts.full) cmd.res_status = 1'b1;
            else cmd.add_box = 1'b1;
          end
          sbli_pkg::OP_TEST: begin
            if (!sts.empty) begin
              cmd.set_res = 1'b0;
              cmd.k_first = 1'b1;
              state_next  = S_RD;
            end
          end
          default: ;
        endcase
      end
      S_RD: begin
        cmd.mem_rd     = 1'b1;
        cmd.axis_first = 1'b1;
        state_next     = S_SA;
      end
      S_SA: begin
        cmd.stage_a = 1'b1;
        state_next  = S_SB;
      end
      S_SB: begin
        cmd.stage_b = 1'b1;
        state_next  = S_CHK;
      end
      S_CHK: begin
        if (sts.slab_fail) box_miss = 1'b1;
        else if (sts.zero_dir) axis_pass = 1'b1;
        else begin
          cmd.cmp_start = 1'b1;
          cmd.cmp_sel   = sbli_pkg::SEL_ENTRY;
          state_next    = S_W0;
        end
      end
      S_W0: begin
        cmd.cmp_sel = sbli_pkg::SEL_EXIT;
        if (sts.cmp_done) begin
          cmd.cmp_start = 1'b1;
          state_next    = S_W1;
        end
      end
      // exit bound lands on the done edge; the span compare starts in the next cycle, from S_SP
      S_W1: begin
        if (sts.cmp_done) state_next = S_SP;
      end
      S_SP: begin
        cmd.cmp_sel   = sbli_pkg::SEL_SPAN;
        cmd.cmp_start = 1'b1;
        state_next    = S_W2;
      end
      S_W2: begin
        cmd.cmp_sel = sbli_pkg::SEL_SPAN;
        if (sts.cmp_done) begin
          if (sts.cmp_fail) box_miss = 1'b1;
          else axis_pass = 1'b1;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.push_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    // box rejected: next box, or a miss after the last one
    if (box_miss) begin
      if (sts.last_box) begin
        cmd.set_res = 1'b1;
        state_next  = S_FIN;
      end else begin
        cmd.k_next = 1'b1;
        state_next = S_RD;
      end
    end
    if (axis_pass) begin
      if (sts.last_axis) begin
        cmd.set_res = 1'b1;
        cmd.res_hit = 1'b1;
        state_next  = S_FIN;
      end else begin
        cmd.axis_next = 1'b1;
        state_next    = S_SA;
      end
    end
  end

endmodule

// ===== hdl/segment_box_list_intersect.sv =====
// top level of the segment versus box-table intersection block
// depends on sbli_pkg, sbli_ifs, sbli_ctrl and sbli_datapath
//
//  channel | modport | payload                          | beat when
//  req     | sink    | op, a_x a_y a_z, b_x b_y b_z     | valid & ready
//  rsp     | source  | hit, status                      | valid & ready
//  cfg     | sink    | data (safety margin, Q16.16)     | valid & ready (ready always 1)
//
// clear, add and unknown ops go from the request beat through S_EXEC to S_FIN.
// a test reads each box row in S_RD; per axis it forms bounds in S_SA and S_SB,
// checks them in S_CHK and, on a nonzero direction, runs three cross-multiply
// compares of ND digits (ND = 3 at 32-bit coordinates), S_SP before the span one,
// on the shared digit-serial multiply unit; one item at a time.
// rst is synchronous; it empties the table and zeroes the margin.
// req stays not ready while an item runs or its result waits to enter the rsp register.
`timescale 1ns / 1ps

module segment_box_list_intersect #(
  parameter int MAX_BOXES  = sbli_pkg::MAX_BOXES_DEF,
  parameter int COORD_BITS = sbli_pkg::COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  sbli_req_if.sink   req,
  sbli_rsp_if.source rsp,
  sbli_cfg_if.sink   cfg
);

  sbli_pkg::cmd_t cmd;
  sbli_pkg::sts_t sts;
  logic [sbli_pkg::FIELD_BITS-1:0] req_a [3];
  logic [sbli_pkg::FIELD_BITS-1:0] req_b [3];
  logic req_ready;

  assign req_a[0] = req.a_x;
  assign req_a[1] = req.a_y;
  assign req_a[2] = req.a_z;
  assign req_b[0] = req.b_x;
  assign req_b[1] = req.b_y;
  assign req_b[2] = req.b_z;
  assign req.ready = req_ready;
  assign cfg.ready = 1'b1;

  sbli_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_fire  (req.valid & req_ready),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sbli_datapath #(
    .MAX_BOXES  (MAX_BOXES),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .req_op     (req.op),
    .req_a      (req_a),
    .req_b      (req_b),
    .cfg_we     (cfg.valid),
    .cfg_data   (cfg.data),
    .out_take   (rsp.ready),
    .out_valid  (rsp.valid),
    .out_hit    (rsp.hit),
    .out_status (rsp.status)
  );

endmodule
